/* hw/rtl/gtp_pkg.sv */
// ----------------------------------------------------------------------------
// gtp_pkg
// Shared types, constants and helpers for the go-to-pose velocity controller.
// ----------------------------------------------------------------------------
package gtp_pkg;

  // sine polynomial coefficients (Q30) and pi in Q29
  localparam logic [30:0] POLY_A  = 31'd1686629713;
  localparam logic [29:0] POLY_B  = 30'd688904866;
  localparam logic [26:0] POLY_C  = 27'd76016977;
  localparam logic [30:0] PI_Q29  = 31'd1686629713;
  localparam logic [15:0] QUARTER = 16'h4000;

  localparam int unsigned SQRT_STEPS = 16;
  localparam int unsigned DIV_STEPS  = 31;
  localparam int unsigned CNT_W      = 5;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned OUT_USER_W = 3;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_GOAL_POS,
    CFG_GOAL_YAW,
    CFG_GAINS,
    CFG_LIN_LIM,
    CFG_TURN_LIM,
    CFG_MIN_SPEED,
    CFG_POS_TOL,
    CFG_HEAD_TOL
  } cfg_idx_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_TAKE,
    OP_RESTART,
    OP_INVALID,
    OP_CAPTURE,
    OP_SIN_INIT,
    OP_SIN_M1,
    OP_SIN_M2,
    OP_SIN_M3,
    OP_SIN_M4,
    OP_ROT_M1,
    OP_ROT_M2,
    OP_ROT_M3,
    OP_ROT_M4,
    OP_GOAL,
    OP_VX,
    OP_VY,
    OP_WZ1,
    OP_WZ2,
    OP_D2A,
    OP_D2B,
    OP_TOL,
    OP_SQA,
    OP_SQB,
    OP_CHK,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_DONE,
    OP_FINISH
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_SIN_INIT,
    S_SIN_M1,
    S_SIN_M2,
    S_SIN_M3,
    S_SIN_M4,
    S_ROT_M1,
    S_ROT_M2,
    S_ROT_M3,
    S_ROT_M4,
    S_GOAL,
    S_VX,
    S_VY,
    S_WZ1,
    S_WZ2,
    S_D2A,
    S_D2B,
    S_TOL,
    S_SQA,
    S_SQB,
    S_CHK,
    S_SQRT_INIT,
    S_SQRT,
    S_DIV_INIT,
    S_DIV,
    S_DIV_DONE,
    S_FINISH
  } ctrl_state_e;

  // sel: cosine for sine ops, y component for divide ops
  typedef struct packed {
    dp_op_e op;
    logic   sel;
  } dp_cmd_t;

  typedef struct packed {
    logic restart;
    logic pose_valid;
    logic scale;
    logic out_busy;
  } dp_status_t;

  // limit to hi first, then to lo (lo wins when inverted)
  function automatic logic signed [15:0] clamp16(input logic signed [67:0] v,
                                                 input logic signed [15:0] hi,
                                                 input logic signed [15:0] lo);
    logic signed [67:0] t;
    t = v;
    if (t > 68'(hi)) t = 68'(hi);
    if (t < 68'(lo)) t = 68'(lo);
    return t[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) r = 32'sh7fffffff;
    else if (v < -37'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* hw/rtl/go_to_pose_velocity_controller.sv */
// ----------------------------------------------------------------------------
// go_to_pose_velocity_controller
// Proportional go-to-pose controller: pose samples in, velocity commands out.
// ----------------------------------------------------------------------------
// Valid poses run the full sequence; the minimum-speed scaling adds a
// 16-step square root and two 31-step divides. Restart and invalid
// samples skip the arithmetic. One item in flight; the next is accepted
// once the result is staged.
// Reset clears the captured frame, both latches and loads register defaults.
// ----------------------------------------------------------------------------
module go_to_pose_velocity_controller (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // pos_x [31:0], pos_y [63:32], heading [79:64]
  input  logic [gtp_pkg::IN_DATA_W-1:0]         s_axis_tdata_i,
  // cmd [0], pose_valid [1]
  input  logic [gtp_pkg::IN_USER_W-1:0]         s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // vel_x [15:0], vel_y [31:16], yaw_rate [47:32]
  output logic [gtp_pkg::OUT_DATA_W-1:0]        m_axis_tdata_o,
  // pos_done [0], goal_done [1], pose_used [2]
  output logic [gtp_pkg::OUT_USER_W-1:0]        m_axis_tuser_o,
  input  logic                                  cfg_we_i,
  input  logic [gtp_pkg::CFG_ADDR_W-1:0]        cfg_addr_i,
  input  logic [gtp_pkg::CFG_DATA_W-1:0]        cfg_wdata_i
);
  import gtp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  gtp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gtp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

endmodule

/* hw/rtl/gtp_ctrl.sv */
// ----------------------------------------------------------------------------
// gtp_ctrl
// Sequencer: steps the datapath through one item and owns the input handshake.
// ----------------------------------------------------------------------------
module gtp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gtp_pkg::dp_status_t status_i,
  output gtp_pkg::dp_cmd_t    cmd_o
);
  import gtp_pkg::*;

  ctrl_state_e        state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               cos_q, cos_d;
  logic               rot2_q, rot2_d;
  logic               ysel_q, ysel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      cos_q   <= 1'b0;
      rot2_q  <= 1'b0;
      ysel_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cos_q   <= cos_d;
      rot2_q  <= rot2_d;
      ysel_q  <= ysel_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cos_d      = cos_q;
    rot2_d     = rot2_q;
    ysel_d     = ysel_q;
    cmd_o.op   = OP_NONE;
    cmd_o.sel  = 1'b0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_TAKE;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status_i.restart) begin
          cmd_o.op = OP_RESTART;
          state_d  = S_FINISH;
        end else if (!status_i.pose_valid) begin
          cmd_o.op = OP_INVALID;
          state_d  = S_FINISH;
        end else begin
          cmd_o.op = OP_CAPTURE;
          cos_d    = 1'b0;
          rot2_d   = 1'b0;
          state_d  = S_SIN_INIT;
        end
      end
      S_SIN_INIT: begin cmd_o.op = OP_SIN_INIT; cmd_o.sel = cos_q; state_d = S_SIN_M1; end
      S_SIN_M1:   begin cmd_o.op = OP_SIN_M1;   cmd_o.sel = cos_q; state_d = S_SIN_M2; end
      S_SIN_M2:   begin cmd_o.op = OP_SIN_M2;   cmd_o.sel = cos_q; state_d = S_SIN_M3; end
      S_SIN_M3:   begin cmd_o.op = OP_SIN_M3;   cmd_o.sel = cos_q; state_d = S_SIN_M4; end
      S_SIN_M4: begin
        cmd_o.op  = OP_SIN_M4;
        cmd_o.sel = cos_q;
        cos_d     = !cos_q;
        state_d   = cos_q ? S_ROT_M1 : S_SIN_INIT;
      end
      S_ROT_M1: begin cmd_o.op = OP_ROT_M1; state_d = S_ROT_M2; end
      S_ROT_M2: begin cmd_o.op = OP_ROT_M2; state_d = S_ROT_M3; end
      S_ROT_M3: begin cmd_o.op = OP_ROT_M3; state_d = S_ROT_M4; end
      S_ROT_M4: begin
        cmd_o.op = OP_ROT_M4;
        rot2_d   = 1'b1;
        state_d  = rot2_q ? S_VX : S_GOAL;
      end
      S_GOAL: begin cmd_o.op = OP_GOAL; state_d = S_SIN_INIT; end
      S_VX:   begin cmd_o.op = OP_VX;   state_d = S_VY;  end
      S_VY:   begin cmd_o.op = OP_VY;   state_d = S_WZ1; end
      S_WZ1:  begin cmd_o.op = OP_WZ1;  state_d = S_WZ2; end
      S_WZ2:  begin cmd_o.op = OP_WZ2;  state_d = S_D2A; end
      S_D2A:  begin cmd_o.op = OP_D2A;  state_d = S_D2B; end
      S_D2B:  begin cmd_o.op = OP_D2B;  state_d = S_TOL; end
      S_TOL:  begin cmd_o.op = OP_TOL;  state_d = S_SQA; end
      S_SQA:  begin cmd_o.op = OP_SQA;  state_d = S_SQB; end
      S_SQB:  begin cmd_o.op = OP_SQB;  state_d = S_CHK; end
      S_CHK:  begin cmd_o.op = OP_CHK;  state_d = S_SQRT_INIT; end
      S_SQRT_INIT: begin
        ysel_d = 1'b0;
        if (status_i.scale) begin
          cmd_o.op = OP_SQRT_INIT;
          cnt_d    = CNT_W'(SQRT_STEPS - 1);
          state_d  = S_SQRT;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd_o.op  = OP_DIV_INIT;
        cmd_o.sel = ysel_q;
        cnt_d     = CNT_W'(DIV_STEPS - 1);
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.op  = OP_DIV_STEP;
        cmd_o.sel = ysel_q;
        cnt_d     = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = S_DIV_DONE;
      end
      S_DIV_DONE: begin
        cmd_o.op  = OP_DIV_DONE;
        cmd_o.sel = ysel_q;
        ysel_d    = 1'b1;
        state_d   = ysel_q ? S_FINISH : S_DIV_INIT;
      end
      S_FINISH: begin
        if (!status_i.out_busy) begin
          cmd_o.op = OP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/gtp_datapath.sv */
// ----------------------------------------------------------------------------
// gtp_datapath
// Registers, config, shared multiplier, square root and divider steps, and
// the result register.
// ----------------------------------------------------------------------------
module gtp_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  gtp_pkg::dp_cmd_t                      cmd_i,
  output gtp_pkg::dp_status_t                   status_o,
  input  logic [gtp_pkg::IN_DATA_W-1:0]         in_data_i,
  input  logic [gtp_pkg::IN_USER_W-1:0]         in_user_i,
  input  logic                                  cfg_we_i,
  input  logic [gtp_pkg::CFG_ADDR_W-1:0]        cfg_addr_i,
  input  logic [gtp_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [gtp_pkg::OUT_DATA_W-1:0]        out_data_o,
  output logic [gtp_pkg::OUT_USER_W-1:0]        out_user_o
);
  import gtp_pkg::*;

  // configuration
  logic [63:0] goal_pos_q;
  logic [15:0] goal_yaw_q;
  logic [31:0] gains_q;
  logic [63:0] lin_lim_q;
  logic [31:0] turn_lim_q;
  logic [14:0] min_speed_q;
  logic [30:0] pos_tol_q;
  logic [15:0] head_tol_q;

  // item and frame state
  logic               it_restart_q, it_valid_q;
  logic signed [31:0] px_q, py_q;
  logic [15:0]        hd_q;
  logic signed [31:0] sx_q, sy_q;
  logic [15:0]        sh_q;
  logic               frame_q, plat_q, glat_q;

  // working registers
  logic signed [33:0] rx_q, ry_q;
  logic [15:0]        ang_q;
  logic [30:0]        x_q, x2_q, poly_q;
  logic               sin_neg_q;
  logic signed [31:0] s_q, c_q;
  logic signed [67:0] acc_q;
  logic signed [35:0] ox_q, oy_q;
  logic signed [16:0] err_q;
  logic signed [33:0] p1_q;
  logic signed [15:0] vx_q, vy_q, wz_q;
  logic [66:0]        d2_q;
  logic [31:0]        sq_q;
  logic               pos_now_q, head_now_q, used_q, scale_q;
  logic [31:0]        sqop_q, sqres_q, one_q;
  logic [15:0]        rem_q;
  logic [30:0]        num_q;
  logic               dneg_q;

  // result register
  logic               out_valid_q;
  logic [15:0]        out_vx_q, out_vy_q, out_wz_q;
  logic               out_pr_q, out_gr_q, out_used_q;

  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic signed [67:0] acc_sum, acc_dif;
  logic [15:0]        sin_arg;
  logic [14:0]        sin_f;
  logic signed [31:0] sxe, sye;
  logic [15:0]        she, hrel;
  logic signed [31:0] gx, gy;
  logic [16:0]        err_mag;
  logic [31:0]        sq_sum;
  logic [16:0]        div_t;
  logic               div_ge;
  logic signed [67:0] dmag;
  logic [15:0]        div_res;
  logic               plat_n, glat_n;

  assign sxe     = frame_q ? sx_q : px_q;
  assign sye     = frame_q ? sy_q : py_q;
  assign she     = frame_q ? sh_q : hd_q;
  assign hrel    = hd_q - sh_q;
  assign gx      = goal_pos_q[63:32];
  assign gy      = goal_pos_q[31:0];
  assign acc_sum = acc_q + prod;
  assign acc_dif = acc_q - prod;
  assign sin_arg = ang_q + (cmd_i.sel ? QUARTER : 16'd0);
  assign sin_f   = sin_arg[14] ? (15'd16384 - {1'b0, sin_arg[13:0]}) : {1'b0, sin_arg[13:0]};
  assign err_mag = err_q[16] ? 17'(-err_q) : 17'(err_q);
  assign sq_sum  = sqres_q + one_q;
  assign div_t   = {rem_q, num_q[30]};
  assign div_ge  = div_t >= {1'b0, sqres_q[15:0]};
  assign dmag    = prod[67] ? -prod : prod;
  assign plat_n  = plat_q | pos_now_q;
  assign glat_n  = glat_q | (plat_n & head_now_q);

  always_comb begin
    if (dneg_q) div_res = (num_q >= 31'd32768) ? 16'h8000 : 16'(-num_q[15:0]);
    else        div_res = (num_q > 31'd32767) ? 16'h7fff : num_q[15:0];
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_SIN_M1: begin ma = {3'b0, x_q};  mb = {3'b0, x_q};    end
      OP_SIN_M2: begin ma = {3'b0, x2_q}; mb = {7'b0, POLY_C}; end
      OP_SIN_M3: begin ma = {3'b0, x2_q}; mb = {3'b0, poly_q}; end
      OP_SIN_M4: begin ma = {3'b0, x_q};  mb = {3'b0, poly_q}; end
      OP_ROT_M1: begin ma = {{2{c_q[31]}}, c_q}; mb = rx_q; end
      OP_ROT_M2: begin ma = {{2{s_q[31]}}, s_q}; mb = ry_q; end
      OP_ROT_M3: begin ma = {{2{c_q[31]}}, c_q}; mb = ry_q; end
      OP_ROT_M4: begin ma = {{2{s_q[31]}}, s_q}; mb = rx_q; end
      OP_VX:     begin ma = {18'b0, gains_q[31:16]}; mb = ox_q[33:0]; end
      OP_VY:     begin ma = {18'b0, gains_q[31:16]}; mb = oy_q[33:0]; end
      OP_WZ1:    begin ma = {{17{err_q[16]}}, err_q}; mb = {18'b0, gains_q[15:0]}; end
      OP_WZ2:    begin ma = p1_q; mb = {3'b0, PI_Q29}; end
      OP_D2A:    begin ma = ox_q[33:0]; mb = ox_q[33:0]; end
      OP_D2B:    begin ma = oy_q[33:0]; mb = oy_q[33:0]; end
      OP_TOL:    begin ma = {3'b0, pos_tol_q}; mb = {3'b0, pos_tol_q}; end
      OP_SQA:    begin ma = {{18{vx_q[15]}}, vx_q}; mb = {{18{vx_q[15]}}, vx_q}; end
      OP_SQB:    begin ma = {{18{vy_q[15]}}, vy_q}; mb = {{18{vy_q[15]}}, vy_q}; end
      OP_CHK:    begin ma = {19'b0, min_speed_q}; mb = {19'b0, min_speed_q}; end
      OP_DIV_INIT: begin
        ma = cmd_i.sel ? {{18{vy_q[15]}}, vy_q} : {{18{vx_q[15]}}, vx_q};
        mb = {19'b0, min_speed_q};
      end
      default: ;
    endcase
  end

  assign prod = ma * mb;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_pos_q  <= '0;
      goal_yaw_q  <= '0;
      gains_q     <= '0;
      lin_lim_q   <= '0;
      turn_lim_q  <= '0;
      min_speed_q <= '0;
      pos_tol_q   <= 31'd6554;
      head_tol_q  <= 16'd1043;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_GOAL_POS:  goal_pos_q  <= cfg_wdata_i;
        CFG_GOAL_YAW:  goal_yaw_q  <= cfg_wdata_i[15:0];
        CFG_GAINS:     gains_q     <= cfg_wdata_i[31:0];
        CFG_LIN_LIM:   lin_lim_q   <= cfg_wdata_i;
        CFG_TURN_LIM:  turn_lim_q  <= cfg_wdata_i[31:0];
        CFG_MIN_SPEED: min_speed_q <= cfg_wdata_i[14:0];
        CFG_POS_TOL:   pos_tol_q   <= cfg_wdata_i[30:0];
        CFG_HEAD_TOL:  head_tol_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // control state: frame, latches, result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q     <= 1'b0;
      plat_q      <= 1'b0;
      glat_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_RESTART: begin
          frame_q <= 1'b0;
          plat_q  <= 1'b0;
          glat_q  <= 1'b0;
        end
        OP_CAPTURE: frame_q <= 1'b1;
        OP_FINISH: begin
          plat_q      <= plat_n;
          glat_q      <= glat_n;
          out_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_TAKE: begin
        it_restart_q <= in_user_i[0];
        it_valid_q   <= in_user_i[1];
        px_q         <= in_data_i[31:0];
        py_q         <= in_data_i[63:32];
        hd_q         <= in_data_i[79:64];
      end
      OP_RESTART, OP_INVALID: begin
        if (cmd_i.op == OP_RESTART) begin
          sx_q <= '0;
          sy_q <= '0;
          sh_q <= '0;
        end
        vx_q       <= '0;
        vy_q       <= '0;
        wz_q       <= '0;
        pos_now_q  <= 1'b0;
        head_now_q <= 1'b0;
        used_q     <= 1'b0;
      end
      OP_CAPTURE: begin
        sx_q   <= sxe;
        sy_q   <= sye;
        sh_q   <= she;
        rx_q   <= 34'(px_q) - 34'(sxe);
        ry_q   <= 34'(py_q) - 34'(sye);
        ang_q  <= she;
        used_q <= 1'b1;
      end
      OP_SIN_INIT: begin
        x_q       <= {sin_f, 16'b0};
        sin_neg_q <= sin_arg[15];
      end
      OP_SIN_M1: x2_q   <= prod[60:30];
      OP_SIN_M2: poly_q <= {1'b0, POLY_B} - prod[60:30];
      OP_SIN_M3: poly_q <= POLY_A - prod[60:30];
      OP_SIN_M4: begin
        if (cmd_i.sel) c_q <= sin_neg_q ? -prod[61:30] : prod[61:30];
        else           s_q <= sin_neg_q ? -prod[61:30] : prod[61:30];
      end
      OP_ROT_M1: acc_q <= prod;
      OP_ROT_M2: ox_q  <= acc_sum[65:30];
      OP_ROT_M3: acc_q <= prod;
      OP_ROT_M4: oy_q  <= acc_dif[65:30];
      OP_GOAL: begin
        rx_q  <= 34'(sat32(37'({{5{gx[31]}}, gx}) - 37'(ox_q)));
        ry_q  <= 34'(sat32(37'({{5{gy[31]}}, gy}) - 37'(oy_q)));
        ang_q <= hrel;
        err_q <= 17'($signed(goal_yaw_q - hrel));
      end
      OP_VX:  vx_q <= clamp16(prod >>> 12, lin_lim_q[47:32], lin_lim_q[63:48]);
      OP_VY:  vy_q <= clamp16(prod >>> 12, lin_lim_q[15:0], lin_lim_q[31:16]);
      OP_WZ1: p1_q <= prod[33:0];
      OP_WZ2: wz_q <= clamp16(prod >>> 40, turn_lim_q[15:0], turn_lim_q[31:16]);
      OP_D2A: d2_q <= prod[66:0];
      OP_D2B: d2_q <= d2_q + prod[66:0];
      OP_TOL: begin
        pos_now_q  <= d2_q < prod[66:0];
        head_now_q <= err_mag < {1'b0, head_tol_q};
      end
      OP_SQA: sq_q <= prod[31:0];
      OP_SQB: sq_q <= sq_q + prod[31:0];
      OP_CHK: scale_q <= !pos_now_q && (sq_q != '0) && (sq_q < prod[31:0]);
      OP_SQRT_INIT: begin
        sqop_q  <= sq_q;
        sqres_q <= '0;
        one_q   <= 32'h4000_0000;
      end
      OP_SQRT_STEP: begin
        if (sqop_q >= sq_sum) begin
          sqop_q  <= sqop_q - sq_sum;
          sqres_q <= (sqres_q >> 1) + one_q;
        end else begin
          sqres_q <= sqres_q >> 1;
        end
        one_q <= one_q >> 2;
      end
      OP_DIV_INIT: begin
        dneg_q <= prod[67];
        num_q  <= dmag[30:0];
        rem_q  <= '0;
      end
      OP_DIV_STEP: begin
        rem_q <= div_ge ? 16'(div_t - {1'b0, sqres_q[15:0]}) : div_t[15:0];
        num_q <= {num_q[29:0], div_ge};
      end
      OP_DIV_DONE: begin
        if (cmd_i.sel) vy_q <= div_res;
        else           vx_q <= div_res;
      end
      OP_FINISH: begin
        out_vx_q   <= (plat_n || glat_n) ? 16'd0 : vx_q;
        out_vy_q   <= (plat_n || glat_n) ? 16'd0 : vy_q;
        out_wz_q   <= (head_now_q || glat_n) ? 16'd0 : wz_q;
        out_pr_q   <= plat_n;
        out_gr_q   <= glat_n;
        out_used_q <= used_q;
      end
      default: ;
    endcase
  end

  assign status_o.restart    = it_restart_q;
  assign status_o.pose_valid = it_valid_q;
  assign status_o.scale      = scale_q;
  assign status_o.out_busy   = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_wz_q, out_vy_q, out_vx_q};
  assign out_user_o  = {out_used_q, out_gr_q, out_pr_q};

  a_goal_implies_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    glat_q |-> plat_q) else $error("goal latch set without position latch");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_used_q) |-> (out_data_o == '0))
    else $error("nonzero command without a used pose");

  a_goal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_gr_q) |-> (out_data_o == '0))
    else $error("nonzero command after goal reached");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.op == OP_FINISH))
    else $error("result raised outside finish step");

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives pose samples, restarts and invalid samples into the go-to-pose
// controller over several register settings, and checks each velocity
// command against a local bit-accurate model or a fixed expected value.
// ----------------------------------------------------------------------------
module tb_top;
  import gtp_pkg::*;

  localparam logic [63:0] SIN_A = 64'd1686629713;
  localparam logic [63:0] SIN_B = 64'd688904866;
  localparam logic [63:0] SIN_C = 64'd76016977;
  localparam longint      PI29  = 64'sd1686629713;
  localparam int          N_PHASES = 7;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;
    logic               pos_done;
    logic               goal_done;
    logic               pose_used;
  } cmd_out_t;

  typedef struct {
    logic               restart;
    logic               valid;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] hd;
    logic               fixed;
    cmd_out_t           res;
  } pose_row_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid_i, s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic [IN_USER_W-1:0]  s_axis_tuser_i;
  logic m_axis_tvalid_o, m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [OUT_USER_W-1:0] m_axis_tuser_o;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  go_to_pose_velocity_controller i_dut (.*);

  // register mirror and controller state
  logic [63:0]        regs [8];
  logic signed [31:0] org_x, org_y;
  logic [15:0]        org_hd;
  logic               have_frame, pos_latch, goal_latch;

  cmd_out_t cmd_queue[$];
  int  errors;
  bit  quiet;
  int  rdy_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("go_to_pose_velocity_controller test failed");
    $finish;
  end

  function automatic longint sin30(logic [15:0] a);
    logic [63:0] f, x, x2, p, o, r;
    f = 64'(a[13:0]);
    if (a[14]) f = 64'd16384 - f;
    x  = f << 16;
    x2 = (x * x) >> 30;
    p  = SIN_B - ((x2 * SIN_C) >> 30);
    o  = SIN_A - ((x2 * p) >> 30);
    r  = (x * o) >> 30;
    return a[15] ? -longint'(r) : longint'(r);
  endfunction

  // rotate (px, py) by minus the binary angle
  function automatic void unrotate(longint px, longint py, logic [15:0] ang,
                                   output longint ox, output longint oy);
    logic signed [127:0] s, c, t;
    logic [15:0] ac;
    ac = ang + 16'h4000;
    s  = sin30(ang);
    c  = sin30(ac);
    t  = c * px + s * py;
    ox = longint'(t >>> 30);
    t  = c * py - s * px;
    oy = longint'(t >>> 30);
  endfunction

  function automatic longint sat_to(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] magn(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic cmd_out_t pose_command(logic restart, logic valid,
                                            logic signed [31:0] x, logic signed [31:0] y,
                                            logic signed [15:0] hd);
    cmd_out_t o;
    longint ex, ey, dx, dy, bx, by, err, vx, vy, wz, kp, kh, m, s, sq;
    logic [15:0] h;
    logic [63:0] d2, tol;
    logic pos_now, head_now;
    o = '0;
    if (restart) begin
      org_x = 0; org_y = 0; org_hd = 0;
      have_frame = 0; pos_latch = 0; goal_latch = 0;
      return o;
    end
    if (!valid) begin
      o.pos_done  = pos_latch;
      o.goal_done = goal_latch;
      return o;
    end
    if (!have_frame) begin
      org_x = x; org_y = y; org_hd = hd;
      have_frame = 1;
    end
    unrotate(longint'(x) - longint'(org_x), longint'(y) - longint'(org_y), org_hd, ex, ey);
    h  = hd - org_hd;
    dx = sat_to(longint'(signed'(regs[CFG_GOAL_POS][63:32])) - ex, -64'sd2147483648,
                64'sd2147483647);
    dy = sat_to(longint'(signed'(regs[CFG_GOAL_POS][31:0])) - ey, -64'sd2147483648,
                64'sd2147483647);
    unrotate(dx, dy, h, bx, by);
    err = longint'(signed'(16'(regs[CFG_GOAL_YAW][15:0] - h)));
    kp = longint'(regs[CFG_GAINS][31:16]);
    kh = longint'(regs[CFG_GAINS][15:0]);

    // max first, then min: min wins when the limits are inverted
    vx = (kp * bx) >>> 12;
    if (vx > longint'(signed'(regs[CFG_LIN_LIM][47:32]))) vx = signed'(regs[CFG_LIN_LIM][47:32]);
    if (vx < longint'(signed'(regs[CFG_LIN_LIM][63:48]))) vx = signed'(regs[CFG_LIN_LIM][63:48]);
    vy = (kp * by) >>> 12;
    if (vy > longint'(signed'(regs[CFG_LIN_LIM][15:0]))) vy = signed'(regs[CFG_LIN_LIM][15:0]);
    if (vy < longint'(signed'(regs[CFG_LIN_LIM][31:16]))) vy = signed'(regs[CFG_LIN_LIM][31:16]);
    wz = (err * kh * PI29) >>> 40;
    if (wz > longint'(signed'(regs[CFG_TURN_LIM][15:0]))) wz = signed'(regs[CFG_TURN_LIM][15:0]);
    if (wz < longint'(signed'(regs[CFG_TURN_LIM][31:16])))
      wz = signed'(regs[CFG_TURN_LIM][31:16]);

    d2  = magn(bx) * magn(bx) + magn(by) * magn(by);
    tol = regs[CFG_POS_TOL];
    pos_now  = d2 < tol * tol;
    head_now = magn(err) < regs[CFG_HEAD_TOL];

    m  = longint'(regs[CFG_MIN_SPEED]);
    sq = vx * vx + vy * vy;
    if (!pos_now && sq > 0 && sq < m * m) begin
      s  = longint'(root_floor(64'(sq)));
      vx = sat_to(vx * m / s, -32768, 32767);
      vy = sat_to(vy * m / s, -32768, 32767);
    end

    pos_latch  = pos_latch || pos_now;
    goal_latch = goal_latch || (pos_latch && head_now);
    if (pos_latch) begin
      vx = 0; vy = 0;
    end
    if (head_now) wz = 0;
    if (goal_latch) begin
      vx = 0; vy = 0; wz = 0;
    end
    o.vel_x = vx[15:0];
    o.vel_y = vy[15:0];
    o.yaw_rate = wz[15:0];
    o.pos_done = pos_latch;
    o.goal_done = goal_latch;
    o.pose_used = 1'b1;
    return o;
  endfunction

  function automatic logic [63:0] reg_mask(int i);
    case (i)
      CFG_GOAL_POS, CFG_LIN_LIM: return '1;
      CFG_GOAL_YAW, CFG_HEAD_TOL: return 64'hFFFF;
      CFG_GAINS, CFG_TURN_LIM:    return 64'hFFFF_FFFF;
      CFG_MIN_SPEED:              return 64'h7FFF;
      default:                    return 64'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic [15:0] rnd_lim(int span);
    return 16'($urandom_range(0, span));
  endfunction

  // register set for one phase: all ones, all zeros, then plausible random values
  task automatic configure(int phase);
    logic [63:0] v [8];
    logic [15:0] a, b, c, d;
    for (int i = 0; i < 8; i++) begin
      if (phase == 1) v[i] = '1;
      else if (phase == 2) v[i] = '0;
      else v[i] = {$urandom, $urandom};
    end
    if (phase > 2) begin
      if ($urandom_range(0, 2) != 0)
        v[CFG_GOAL_POS] = {32'($signed($urandom) >>> 13), 32'($signed($urandom) >>> 13)};
      if ($urandom_range(0, 1) != 0) v[CFG_GAINS] = {16'($urandom_range(0, 2048)),
                                                    16'($urandom_range(0, 2048))};
      a = -rnd_lim(12000); b = rnd_lim(12000); c = -rnd_lim(12000); d = rnd_lim(12000);
      if ($urandom_range(0, 3) != 0) v[CFG_LIN_LIM] = {a, b, c, d};
      if ($urandom_range(0, 3) != 0) v[CFG_TURN_LIM] = {32'd0, -rnd_lim(9000), rnd_lim(9000)};
      if ($urandom_range(0, 2) != 0) v[CFG_MIN_SPEED] = 64'($urandom_range(0, 6000));
      v[CFG_POS_TOL] = 64'($urandom_range(1, 1 << $urandom_range(4, 20)));
      v[CFG_HEAD_TOL] = 64'($urandom_range(0, 1 << $urandom_range(4, 15)));
    end
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= cfg_idx_e'(i);
      cfg_wdata_i <= v[i];
      regs[i] = v[i] & reg_mask(i);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_pose(pose_row_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {r.hd, r.y, r.x};
    s_axis_tuser_i  <= {r.valid, r.restart};
    if (r.fixed) begin
      void'(pose_command(r.restart, r.valid, r.x, r.y, r.hd));
      cmd_queue.push_back(r.res);
    end else begin
      cmd_queue.push_back(pose_command(r.restart, r.valid, r.x, r.y, r.hd));
    end
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (cmd_queue.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // receiver stalls in bursts
  always @(posedge clk_i) begin
    if (rdy_hold > 0) begin
      rdy_hold <= rdy_hold - 1;
    end else if (quiet || $urandom_range(0, 5) != 0) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= 1'b0;
      rdy_hold <= $urandom_range(0, 8);
    end
  end

  always @(posedge clk_i) begin
    cmd_out_t got, want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[15:0], m_axis_tdata_o[31:16], m_axis_tdata_o[47:32],
             m_axis_tuser_o[0], m_axis_tuser_o[1], m_axis_tuser_o[2]};
      if (cmd_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected command %p", got);
      end else begin
        want = cmd_queue.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  initial begin
    pose_row_t tbl [$];
    pose_row_t r;
    int sh;
    errors = 0; quiet = 0; rdy_hold = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0; s_axis_tdata_i = '0; s_axis_tuser_i = '0;
    m_axis_tready_i = 1'b0;
    cfg_we_i = 1'b0; cfg_addr_i = CFG_GOAL_POS; cfg_wdata_i = '0;
    for (int i = 0; i < 8; i++) regs[i] = '0;
    regs[CFG_POS_TOL] = 64'd6554;
    regs[CFG_HEAD_TOL] = 64'd1043;
    org_x = 0; org_y = 0; org_hd = 0;
    have_frame = 0; pos_latch = 0; goal_latch = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, register defaults: zero goal and gains, so the first valid sample reaches the goal
    tbl = '{
      '{0, 0, 32'sh0,        32'sh0,        16'sh0,    1, '{0, 0, 0, 0, 0, 0}},
      '{1, 1, 32'sh1234,     32'sh5678,     16'sh100,  1, '{0, 0, 0, 0, 0, 0}},
      '{0, 1, 32'sh7fffffff, 32'sh80000000, 16'sh8000, 1, '{0, 0, 0, 1, 1, 1}},
      '{0, 1, 32'sh80000000, 32'sh7fffffff, 16'sh7fff, 0, '{0, 0, 0, 0, 0, 0}},
      '{0, 0, 32'shffffffff, 32'shffffffff, 16'shffff, 1, '{0, 0, 0, 1, 1, 0}},
      '{1, 0, 32'sh0,        32'sh0,        16'sh0,    1, '{0, 0, 0, 0, 0, 0}},
      '{0, 1, 32'sh80000000, 32'sh80000000, 16'sh4000, 1, '{0, 0, 0, 1, 1, 1}},
      '{0, 1, 32'sh7fffffff, 32'sh7fffffff, 16'shc000, 0, '{0, 0, 0, 0, 0, 0}},
      '{1, 1, 32'sh7fffffff, 32'sh7fffffff, 16'sh7fff, 1, '{0, 0, 0, 0, 0, 0}},
      '{0, 1, 32'sh10000,    -32'sh10000,   16'sh2000, 0, '{0, 0, 0, 0, 0, 0}},
      '{0, 1, 32'sh20000,    32'sh1,        -16'sh2000, 0, '{0, 0, 0, 0, 0, 0}}
    };
    foreach (tbl[i]) send_pose(tbl[i]);
    wait_drained();

    for (int ph = 1; ph < N_PHASES; ph++) begin
      quiet = (ph == N_PHASES - 1);
      configure(ph);
      for (int n = 0; n < 150; n++) begin
        r = '{0, 1, 0, 0, 0, 0, '0};
        r.restart = ($urandom_range(0, 24) == 0);
        r.valid   = ($urandom_range(0, 9) != 0);
        sh = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(8, 16);
        r.x  = $signed($urandom) >>> sh;
        r.y  = $signed($urandom) >>> sh;
        r.hd = 16'($urandom);
        if (sh != 0) begin
          r.x = r.x + signed'(regs[CFG_GOAL_POS][63:32]);
          r.y = r.y + signed'(regs[CFG_GOAL_POS][31:0]);
        end
        send_pose(r);
      end
      wait_drained();
    end

    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("go_to_pose_velocity_controller test passed");
    end else begin
      $display("go_to_pose_velocity_controller test failed");
    end
    $finish;
  end

endmodule
